FILE: design/assert_macros.svh
// Assertion macros shared by the cell allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define FCFLA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cell allocator assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define FCFLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cell allocator assertion failed");
`else
`define FCFLA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define FCFLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: design/fcfla_pkg.sv
// Shared constants, codes and controller/datapath structs of the cell allocator.
package fcfla_pkg;

    localparam int MAX_CELLS      = 1024;
    localparam int ALIGN_BYTES    = 8;
    localparam int MIN_CELL_BYTES = 4;

    localparam int IDX_W      = $clog2(MAX_CELLS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 32;
    localparam int CELL_W     = 16;
    localparam int DVD_W      = IDX_W + CELL_W;
    localparam int SPAN_W     = CNT_W + CELL_W;
    localparam int CMP_W      = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;
    localparam int STEP_W     = $clog2(IDX_W + 1);
    localparam int ACT_W      = 2;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // stream payload layout, lowest field first
    localparam int S_ACT_LSB     = 0;
    localparam int S_ADDR_LSB    = S_ACT_LSB + ACT_W;
    localparam int S_TDATA_W     = ((ACT_W + ADDR_W + 7) / 8) * 8;
    localparam int M_ST_LSB      = 0;
    localparam int M_ADDR_LSB    = M_ST_LSB + ST_W;
    localparam int M_FREE_LSB    = M_ADDR_LSB + ADDR_W;
    localparam int M_TOTAL_LSB   = M_FREE_LSB + CNT_W;
    localparam int M_TDATA_W     = ((ST_W + ADDR_W + 2 * CNT_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] NIL_INDEX = CNT_W'(MAX_CELLS);

    localparam logic [ACT_W-1:0] ACT_INIT  = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_ALLOC = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_FREE  = ACT_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POOL = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CELL = CFG_IDX_W'(2);

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_MEM   = 2'd2,
        ST_BAD_ADDR = 2'd3
    } status_t;

    typedef struct packed {
        logic    accept;
        logic    status_load;
        status_t status_code;
        logic    div_start;
        logic    div_free;
        logic    pool_load;
        logic    pool_full;
        logic    link_write;
        logic    link_done;
        logic    alloc_pop;
        logic    free_push;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] in_action;
        logic             size_ok;
        logic             pool_big;
        logic             div_done;
        logic             quot_zero;
        logic             rem_zero;
        logic             head_nil;
        logic             addr_bad;
        logic             link_last;
    } dp_stat_t;

endpackage

FILE: design/fcfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/fcfla_div.sv
// Restoring divider, one quotient bit per cycle, quotient limited to IDX_W bits.
module fcfla_div import fcfla_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [CELL_W-1:0] divisor,
    output logic              done,
    output logic [IDX_W-1:0]  quot,
    output logic              rem_zero
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  dsh_reg;
    logic [IDX_W-1:0]  quot_reg;
    logic              fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            // pulse done after the last quotient bit
            done_reg <= !start && busy_reg && (step_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(IDX_W - 1);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // dividend is below divisor shifted by IDX_W, so IDX_W steps suffice
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsh_reg <= DVD_W'(divisor) << (IDX_W - 1);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= IDX_W'({quot_reg, fits});
        end
    end

    assign done     = done_reg;
    assign quot     = quot_reg;
    assign rem_zero = rem_reg == '0;

endmodule

FILE: design/fcfla_dp.sv
// Datapath: configuration, pool registers, link memory, divider and result registers.
module fcfla_dp import fcfla_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    logic [ADDR_W-1:0] base_cfg_reg;
    logic [ADDR_W-1:0] pool_cfg_reg;
    logic [CELL_W-1:0] cell_cfg_reg;

    logic [ADDR_W-1:0] pool_base_reg;
    logic [CELL_W-1:0] pool_cell_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  free_reg;
    logic [CNT_W-1:0]  head_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [DVD_W-1:0]  prod_reg;
    logic [IDX_W-1:0]  link_idx_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    status_t           res_status_reg;
    logic [ADDR_W-1:0] res_addr_reg;

    status_t           out_status_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [CNT_W-1:0]  out_free_reg;
    logic [CNT_W-1:0]  out_total_reg;

    logic [ADDR_W-1:0] offset;
    logic [DVD_W-1:0]  big_limit;
    logic [DVD_W-1:0]  div_dividend;
    logic [CELL_W-1:0] div_divisor;
    logic              div_done;
    logic [IDX_W-1:0]  div_quot;
    logic              div_rem_zero;
    logic              link_last;
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [CNT_W-1:0]  ram_wr_data;
    logic [CNT_W-1:0]  ram_rd_data;
    logic [CNT_W-1:0]  link_next;
    logic [CNT_W-1:0]  pool_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_cfg_reg <= '0;
            pool_cfg_reg <= '0;
            cell_cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_BASE: base_cfg_reg <= cfg_wr_data;
                CFG_POOL: pool_cfg_reg <= cfg_wr_data;
                CFG_CELL: cell_cfg_reg <= cfg_wr_data[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    assign offset    = in_addr_reg - pool_base_reg;
    assign big_limit = DVD_W'(cell_cfg_reg) * DVD_W'(MAX_CELLS);
    assign link_last = (CNT_W'(link_idx_reg) + CNT_W'(1)) == total_reg;
    assign link_next = (ram_rd_data > NIL_INDEX) ? NIL_INDEX : ram_rd_data;
    assign pool_count = cmd.pool_full ? CNT_W'(MAX_CELLS) : CNT_W'(div_quot);

    assign div_dividend = cmd.div_free ? offset[DVD_W-1:0] : pool_cfg_reg[DVD_W-1:0];
    assign div_divisor  = cmd.div_free ? pool_cell_reg : cell_cfg_reg;

    fcfla_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem_zero (div_rem_zero)
    );

    // the init sweep and a free share the single write port
    assign ram_wr_en   = cmd.link_write | cmd.free_push;
    assign ram_wr_addr = cmd.link_write ? link_idx_reg : div_quot;
    assign ram_wr_data = cmd.link_write
                       ? (link_last ? NIL_INDEX : CNT_W'(link_idx_reg) + CNT_W'(1))
                       : head_reg;

    fcfla_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_CELLS)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (head_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        span_reg <= SPAN_W'(total_reg) * SPAN_W'(pool_cell_reg);
        prod_reg <= DVD_W'(head_reg[IDX_W-1:0]) * DVD_W'(pool_cell_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= '0;
            pool_cell_reg <= '0;
            total_reg     <= '0;
            free_reg      <= '0;
            head_reg      <= NIL_INDEX;
        end else begin
            if (cmd.pool_load) begin
                pool_base_reg <= base_cfg_reg;
                pool_cell_reg <= cell_cfg_reg;
                total_reg     <= pool_count;
            end
            if (cmd.link_done) begin
                head_reg <= '0;
                free_reg <= total_reg;
            end
            if (cmd.alloc_pop) begin
                head_reg <= link_next;
                if (free_reg != '0) begin
                    free_reg <= free_reg - 1'b1;
                end
            end
            if (cmd.free_push) begin
                head_reg <= CNT_W'(div_quot);
                if (free_reg < total_reg) begin
                    free_reg <= free_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_addr_reg    <= s_tdata[S_ADDR_LSB +: ADDR_W];
            res_status_reg <= ST_OK;
            res_addr_reg   <= '0;
        end
        if (cmd.status_load) begin
            res_status_reg <= cmd.status_code;
        end
        if (cmd.alloc_pop) begin
            res_addr_reg <= pool_base_reg + ADDR_W'(prod_reg);
        end
        if (cmd.pool_load) begin
            link_idx_reg <= '0;
        end else if (cmd.link_write) begin
            link_idx_reg <= link_idx_reg + 1'b1;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_free_reg   <= free_reg;
            out_total_reg  <= total_reg;
        end
    end

    assign stat.in_action = s_tdata[S_ACT_LSB +: ACT_W];
    assign stat.size_ok   = (cell_cfg_reg >= CELL_W'(MIN_CELL_BYTES))
                         && ((cell_cfg_reg % CELL_W'(ALIGN_BYTES)) == '0);
    assign stat.pool_big  = pool_cfg_reg >= ADDR_W'(big_limit);
    assign stat.div_done  = div_done;
    assign stat.quot_zero = div_quot == '0;
    assign stat.rem_zero  = div_rem_zero;
    assign stat.head_nil  = head_reg == NIL_INDEX;
    assign stat.addr_bad  = (in_addr_reg < pool_base_reg)
                         || (CMP_W'(offset) >= CMP_W'(span_reg))
                         || (pool_cell_reg == '0);
    assign stat.link_last = link_last;

    assign m_tdata = M_TDATA_W'({out_total_reg, out_free_reg, out_addr_reg, out_status_reg});

endmodule

FILE: design/fcfla_ctrl.sv
// Controller: sequences init, alloc and free requests and owns both handshakes.
module fcfla_ctrl import fcfla_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_CHK,
        S_INIT_DIV,
        S_INIT_LINK,
        S_ALLOC,
        S_ALLOC_POP,
        S_FREE_CHK,
        S_FREE_DIV,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    unique case (stat.in_action)
                        ACT_INIT:  state_next = S_INIT_CHK;
                        ACT_ALLOC: state_next = S_ALLOC;
                        ACT_FREE:  state_next = S_FREE_CHK;
                        default:   state_next = S_FINISH;
                    endcase
                end
            end
            S_INIT_CHK: begin
                if (!stat.size_ok) begin
                    cmd.status_load = 1'b1;
                    cmd.status_code = ST_BAD_SIZE;
                    state_next      = S_FINISH;
                end else if (stat.pool_big) begin
                    cmd.pool_load = 1'b1;
                    cmd.pool_full = 1'b1;
                    state_next    = S_INIT_LINK;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_INIT_DIV;
                end
            end
            S_INIT_DIV: begin
                if (stat.div_done) begin
                    if (stat.quot_zero) begin
                        cmd.status_load = 1'b1;
                        cmd.status_code = ST_BAD_SIZE;
                        state_next      = S_FINISH;
                    end else begin
                        cmd.pool_load = 1'b1;
                        state_next    = S_INIT_LINK;
                    end
                end
            end
            S_INIT_LINK: begin
                // one link entry per cycle, then point the head at cell zero
                cmd.link_write = 1'b1;
                if (stat.link_last) begin
                    cmd.link_done = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_ALLOC: begin
                if (stat.head_nil) begin
                    cmd.status_load = 1'b1;
                    cmd.status_code = ST_NO_MEM;
                    state_next      = S_FINISH;
                end else begin
                    state_next = S_ALLOC_POP;
                end
            end
            S_ALLOC_POP: begin
                cmd.alloc_pop = 1'b1;
                state_next    = S_FINISH;
            end
            S_FREE_CHK: begin
                if (stat.addr_bad) begin
                    cmd.status_load = 1'b1;
                    cmd.status_code = ST_BAD_ADDR;
                    state_next      = S_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_free  = 1'b1;
                    state_next    = S_FREE_DIV;
                end
            end
            S_FREE_DIV: begin
                if (stat.div_done) begin
                    if (!stat.rem_zero) begin
                        cmd.status_load = 1'b1;
                        cmd.status_code = ST_BAD_ADDR;
                    end else begin
                        cmd.free_push = 1'b1;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;

endmodule

FILE: design/fixed_cell_free_list_allocator.sv
// Top level of the fixed-size cell allocator with a LIFO free list.
//
// Requests enter on the s_ stream: action 0 initializes the pool from the
// base address, pool size and cell size registers, action 1 allocates a cell,
// action 2 frees the cell at the given address. Each request yields exactly one
// result on the m_ stream with status, allocated address and free/total counts.
// Configuration registers are written through cfg_wr_en/index/data and are
// sampled when an init request runs; write them only while the block is idle.
// One request is in flight at a time. An alloc checks the list head, then pops
// it when the list is not empty; a free runs the range check, then the divider
// (one quotient bit per cycle) when the address passes it; an init checks the
// cell size, divides the pool size by it unless the pool holds MAX_CELLS or more
// cells, and stops there for a bad cell size or when no cell fits, else fills
// the link memory, which takes one entry per cycle. Action 3 goes straight to
// the result. The result turns valid in the cycle the next request can be taken.
// The result sits in an output register, so a new request is taken while an
// earlier result still waits; a stalled receiver only holds the block at the
// end of the next request. Reset empties the free list and zeroes the counts,
// pool and configuration registers; the link memory needs no clearing pass.
`include "assert_macros.svh"

module fixed_cell_free_list_allocator import fcfla_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // action[1:0], free_addr[33:2]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // status[1:0], alloc_addr[33:2],
                                             // free_cells[44:34], total_cells[55:45]
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fcfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fcfla_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .cmd          (cmd),
        .stat         (stat),
        .m_tdata      (m_tdata)
    );

    logic [ST_W-1:0]   m_status;
    logic [ADDR_W-1:0] m_alloc_addr;
    logic [CNT_W-1:0]  m_free;
    logic [CNT_W-1:0]  m_total;

    assign m_status     = m_tdata[M_ST_LSB +: ST_W];
    assign m_alloc_addr = m_tdata[M_ADDR_LSB +: ADDR_W];
    assign m_free       = m_tdata[M_FREE_LSB +: CNT_W];
    assign m_total      = m_tdata[M_TOTAL_LSB +: CNT_W];

    `FCFLA_ASSERT_IMPL(a_free_within_total, aclk, aresetn, m_tvalid, m_free <= m_total)
    `FCFLA_ASSERT_IMPL(a_total_clamped, aclk, aresetn, m_tvalid, m_total <= CNT_W'(MAX_CELLS))
    `FCFLA_ASSERT_IMPL(a_fail_no_addr, aclk, aresetn, m_tvalid && m_status != ST_OK, m_alloc_addr == '0)
    `FCFLA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule
